@@ src/pebs_pkg.sv @@
// Shared constants and types for the panel encoder and button scanner.
`timescale 1ns / 1ps
`default_nettype none

package pebs_pkg;

    // Fixed widths of the panel snapshot and result fields.
    localparam int PANEL_W      = 16;
    localparam int NOW_W        = 16;
    localparam int THRESH_W     = 16;
    localparam int SHIFT_IDX_W  = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 16;
    localparam int STEP_W       = 2;
    localparam int SLOT_W       = 2;

    // Port slots on the block; the parameters may use fewer of them.
    localparam int MAX_ENCODERS = 4;
    localparam int MAX_BUTTONS  = 6;
    localparam int BUTTON_BASE  = 10;

    // Parameter defaults.
    localparam int DEF_ENCODER_COUNT = 4;
    localparam int DEF_BUTTON_COUNT  = 6;
    localparam int DEF_TICK_WIDTH    = 16;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_DOUBLE_CLICK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_CLICK   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SHIFT_INDEX  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW   = 3'd3;

    // Configuration reset values.
    localparam logic [THRESH_W-1:0]    RST_DOUBLE_CLICK = 16'd20;
    localparam logic [THRESH_W-1:0]    RST_LONG_CLICK   = 16'd100;
    localparam logic [SHIFT_IDX_W-1:0] RST_SHIFT_INDEX  = 3'd0;
    localparam logic                   RST_ACTIVE_LOW   = 1'b1;

    // Encoder step codes.
    localparam logic signed [STEP_W-1:0] STEP_NONE = 2'sb00;
    localparam logic signed [STEP_W-1:0] STEP_UP   = 2'sb01;
    localparam logic signed [STEP_W-1:0] STEP_DOWN = 2'sb11;

    // Encoder slot codes.
    localparam logic [SLOT_W-1:0] SLOT_NORMAL     = 2'd0;
    localparam logic [SLOT_W-1:0] SLOT_SHIFT      = 2'd1;
    localparam logic [SLOT_W-1:0] SLOT_BUTTON     = 2'd2;
    localparam logic [SLOT_W-1:0] SLOT_BTN_SHIFT  = 2'd3;

    typedef struct packed {
        logic [THRESH_W-1:0] double_click;
        logic [THRESH_W-1:0] long_click;
    } t_thresh;

    typedef struct packed {
        logic click;
        logic dbl;
        logic lng;
    } t_btn_evt;

    typedef struct packed {
        logic signed [STEP_W-1:0] step;
        logic [SLOT_W-1:0]        slot;
    } t_enc_res;

endpackage

`default_nettype wire

@@ src/pebs_button.sv @@
// Click, double-click and long-click detector for one panel button.
`timescale 1ns / 1ps
`default_nettype none

module pebs_button #(
    parameter int TICK_WIDTH = pebs_pkg::DEF_TICK_WIDTH
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_fire,
    input  wire logic                  i_down,
    input  wire logic [TICK_WIDTH-1:0] i_now,
    input  wire pebs_pkg::t_thresh     i_thresh,
    output pebs_pkg::t_btn_evt         o_evt
);

    localparam int CMP_W = (TICK_WIDTH > pebs_pkg::THRESH_W) ? TICK_WIDTH
                                                              : pebs_pkg::THRESH_W;

    logic                  r_prev_down;
    logic                  r_pressed_once;
    logic [TICK_WIDTH-1:0] r_last_press;

    logic                  n_pressed_once;
    logic [TICK_WIDTH-1:0] n_last_press;

    logic [TICK_WIDTH-1:0] diff;
    logic [CMP_W-1:0]      diff_ext;
    logic [CMP_W-1:0]      diff_now;
    logic [CMP_W-1:0]      dbl_ext;
    logic [CMP_W-1:0]      lng_ext;
    logic                  press_edge;
    logic                  recorded;

    assign diff       = i_now - r_last_press;
    assign diff_ext   = CMP_W'(diff);
    assign dbl_ext    = CMP_W'(i_thresh.double_click);
    assign lng_ext    = CMP_W'(i_thresh.long_click);
    assign press_edge = i_down && !r_prev_down;

    always_comb begin
        n_pressed_once = r_pressed_once;
        n_last_press   = r_last_press;
        o_evt          = '0;
        recorded       = 1'b0;

        if (press_edge) begin
            if (r_pressed_once) begin
                if (diff_ext < dbl_ext) begin
                    o_evt.dbl      = 1'b1;
                    n_pressed_once = 1'b0;
                end
            end else begin
                n_last_press   = i_now;
                n_pressed_once = 1'b1;
                recorded       = 1'b1;
            end
        end

        // A press recorded in this beat has zero elapsed time.
        diff_now = recorded ? '0 : diff_ext;

        if (n_pressed_once) begin
            if (i_down) begin
                if (diff_now > lng_ext) begin
                    o_evt.lng      = 1'b1;
                    n_pressed_once = 1'b0;
                end
            end else if (diff_now > lng_ext) begin
                n_pressed_once = 1'b0;
            end else if (diff_now > dbl_ext) begin
                o_evt.click    = 1'b1;
                n_pressed_once = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_down    <= 1'b0;
            r_pressed_once <= 1'b0;
            r_last_press   <= '0;
        end else if (i_fire) begin
            r_prev_down    <= i_down;
            r_pressed_once <= n_pressed_once;
            r_last_press   <= n_last_press;
        end
    end

endmodule

`default_nettype wire

@@ src/pebs_encoder.sv @@
// Quadrature step decoder and slot selection for one rotary encoder.
`timescale 1ns / 1ps
`default_nettype none

module pebs_encoder (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_fire,
    input  wire logic          i_a,
    input  wire logic          i_b,
    input  wire logic          i_own_down,
    input  wire logic          i_shift_down,
    output pebs_pkg::t_enc_res o_res
);

    logic r_prev_a;

    always_comb begin
        o_res.step = pebs_pkg::STEP_NONE;
        o_res.slot = pebs_pkg::SLOT_NORMAL;
        if (i_a != r_prev_a) begin
            o_res.step = (i_b == i_a) ? pebs_pkg::STEP_UP : pebs_pkg::STEP_DOWN;
            if (i_own_down) begin
                o_res.slot = i_shift_down ? pebs_pkg::SLOT_BTN_SHIFT
                                          : pebs_pkg::SLOT_BUTTON;
            end else begin
                o_res.slot = i_shift_down ? pebs_pkg::SLOT_SHIFT
                                          : pebs_pkg::SLOT_NORMAL;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_a <= 1'b0;
        end else if (i_fire) begin
            r_prev_a <= i_a;
        end
    end

endmodule

`default_nettype wire

@@ src/panel_encoder_button_scanner.sv @@
// Top level of the panel encoder and button scanner.
//
//  channel  direction  handshake                 payload
//  in       sink       i_in_valid / o_in_stall   i_panel_bits, i_now_tick
//  out      source     o_out_valid / i_out_stall o_encN_step/slot, o_*_mask
//  cfg      sink       i_cfg_we                  i_cfg_index, i_cfg_data
//
// One snapshot per clock is accepted while the output is not stalled; the input beat
// lands in the input register and its result is registered into the result register.
// Button and encoder history updates as a beat moves into the result register.
// A stalled output backs up into the input register and then stalls the input.
// Synchronous active-low reset clears history and handshake state and restores
// the configuration defaults.
`timescale 1ns / 1ps
`default_nettype none

module panel_encoder_button_scanner #(
    parameter int ENCODER_COUNT = pebs_pkg::DEF_ENCODER_COUNT,
    parameter int BUTTON_COUNT  = pebs_pkg::DEF_BUTTON_COUNT,
    parameter int TICK_WIDTH    = pebs_pkg::DEF_TICK_WIDTH
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    // Input snapshots
    input  wire logic                                i_in_valid,
    output logic                                     o_in_stall,
    input  wire logic [pebs_pkg::PANEL_W-1:0]        i_panel_bits,
    input  wire logic [pebs_pkg::NOW_W-1:0]          i_now_tick,
    // Results
    output logic                                     o_out_valid,
    input  wire logic                                i_out_stall,
    output logic signed [pebs_pkg::STEP_W-1:0]       o_enc0_step,
    output logic [pebs_pkg::SLOT_W-1:0]              o_enc0_slot,
    output logic signed [pebs_pkg::STEP_W-1:0]       o_enc1_step,
    output logic [pebs_pkg::SLOT_W-1:0]              o_enc1_slot,
    output logic signed [pebs_pkg::STEP_W-1:0]       o_enc2_step,
    output logic [pebs_pkg::SLOT_W-1:0]              o_enc2_slot,
    output logic signed [pebs_pkg::STEP_W-1:0]       o_enc3_step,
    output logic [pebs_pkg::SLOT_W-1:0]              o_enc3_slot,
    output logic [pebs_pkg::MAX_BUTTONS-1:0]         o_click_mask,
    output logic [pebs_pkg::MAX_BUTTONS-1:0]         o_double_click_mask,
    output logic [pebs_pkg::MAX_BUTTONS-1:0]         o_long_click_mask,
    // Configuration writes
    input  wire logic                                i_cfg_we,
    input  wire logic [pebs_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  wire logic [pebs_pkg::CFG_DATA_W-1:0]     i_cfg_data
);

    localparam int NB    = pebs_pkg::MAX_BUTTONS;
    localparam int NE    = pebs_pkg::MAX_ENCODERS;
    localparam int CMP_W = (TICK_WIDTH > pebs_pkg::NOW_W) ? TICK_WIDTH : pebs_pkg::NOW_W;

    // Configuration registers.
    pebs_pkg::t_thresh                   r_thresh;
    logic [pebs_pkg::SHIFT_IDX_W-1:0]    r_shift_idx;
    logic                                r_active_low;

    // Input register.
    logic                                r_in_valid;
    logic [pebs_pkg::PANEL_W-1:0]        r_bits;
    logic [pebs_pkg::NOW_W-1:0]          r_now;

    // Result register.
    logic                                r_out_valid;
    pebs_pkg::t_enc_res                  r_enc [NE];
    logic [NB-1:0]                       r_click;
    logic [NB-1:0]                       r_dbl;
    logic [NB-1:0]                       r_lng;

    logic                                out_free;
    logic                                in_fire;
    logic                                proc;
    logic [CMP_W-1:0]                    now_ext;
    logic [TICK_WIDTH-1:0]               now_t;
    logic [NB-1:0]                       down;
    logic [7:0]                          down_ext;
    logic                                shift_down;
    pebs_pkg::t_btn_evt                  evt [NB];
    pebs_pkg::t_enc_res                  enc [NE];

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;
    assign proc       = r_in_valid && out_free;

    assign now_ext = CMP_W'(r_now);
    assign now_t   = now_ext[TICK_WIDTH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh.double_click <= pebs_pkg::RST_DOUBLE_CLICK;
            r_thresh.long_click   <= pebs_pkg::RST_LONG_CLICK;
            r_shift_idx           <= pebs_pkg::RST_SHIFT_INDEX;
            r_active_low          <= pebs_pkg::RST_ACTIVE_LOW;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                pebs_pkg::REG_DOUBLE_CLICK: r_thresh.double_click <= i_cfg_data;
                pebs_pkg::REG_LONG_CLICK:   r_thresh.long_click   <= i_cfg_data;
                pebs_pkg::REG_SHIFT_INDEX:
                    r_shift_idx <= i_cfg_data[pebs_pkg::SHIFT_IDX_W-1:0];
                pebs_pkg::REG_ACTIVE_LOW:   r_active_low <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_bits <= i_panel_bits;
            r_now  <= i_now_tick;
        end
    end

    // Button levels; buttons beyond the configured count never read as down.
    always_comb begin
        for (int b = 0; b < NB; b++) begin
            down[b] = (b < BUTTON_COUNT) &&
                      (r_bits[pebs_pkg::BUTTON_BASE + b] ^ r_active_low);
        end
    end

    assign down_ext   = 8'(down);
    assign shift_down = (r_shift_idx < pebs_pkg::SHIFT_IDX_W'(BUTTON_COUNT)) &&
                        down_ext[r_shift_idx];

    for (genvar b = 0; b < NB; b++) begin : g_btn
        if (b < BUTTON_COUNT) begin : g_on
            pebs_button #(
                .TICK_WIDTH (TICK_WIDTH)
            ) u_btn (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_fire   (proc),
                .i_down   (down[b]),
                .i_now    (now_t),
                .i_thresh (r_thresh),
                .o_evt    (evt[b])
            );
        end else begin : g_off
            assign evt[b] = '0;
        end
    end

    for (genvar e = 0; e < NE; e++) begin : g_enc
        if (e < ENCODER_COUNT) begin : g_on
            pebs_encoder u_enc (
                .i_clk        (i_clk),
                .i_rst_n      (i_rst_n),
                .i_fire       (proc),
                .i_a          (r_bits[2*e]),
                .i_b          (r_bits[2*e+1]),
                .i_own_down   (down[e]),
                .i_shift_down (shift_down),
                .o_res        (enc[e])
            );
        end else begin : g_off
            assign enc[e] = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            for (int e = 0; e < NE; e++) begin
                r_enc[e] <= enc[e];
            end
            for (int b = 0; b < NB; b++) begin
                r_click[b] <= evt[b].click;
                r_dbl[b]   <= evt[b].dbl;
                r_lng[b]   <= evt[b].lng;
            end
        end
    end

    assign o_out_valid         = r_out_valid;
    assign o_enc0_step         = r_enc[0].step;
    assign o_enc0_slot         = r_enc[0].slot;
    assign o_enc1_step         = r_enc[1].step;
    assign o_enc1_slot         = r_enc[1].slot;
    assign o_enc2_step         = r_enc[2].step;
    assign o_enc2_slot         = r_enc[2].slot;
    assign o_enc3_step         = r_enc[3].step;
    assign o_enc3_slot         = r_enc[3].slot;
    assign o_click_mask        = r_click;
    assign o_double_click_mask = r_dbl;
    assign o_long_click_mask   = r_lng;

endmodule

`default_nettype wire

@@ bench/panel_encoder_button_scanner_tb.sv @@
// Self-checking testbench for the panel encoder and button scanner.
`timescale 1ns / 1ps

module panel_encoder_button_scanner_tb;
    import pebs_pkg::*;

    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int PHASE_BEATS = 300;
    localparam int HOLD_AT_BEAT = 480;
    localparam int HOLD_CYCLES = 200;
    localparam int REPORT_CAP = 60;

    localparam logic [3:0][STEP_W-1:0] ALL_NONE = {4{STEP_NONE}};
    localparam logic [3:0][STEP_W-1:0] ALL_UP = {4{STEP_UP}};
    localparam logic [3:0][STEP_W-1:0] ALL_DOWN = {4{STEP_DOWN}};
    localparam logic [3:0][STEP_W-1:0] ENC0_DOWN = {STEP_NONE, STEP_NONE, STEP_NONE, STEP_DOWN};

    typedef struct packed {
        logic [3:0][STEP_W-1:0]      step;
        logic [3:0][SLOT_W-1:0]      slot;
        logic [MAX_BUTTONS-1:0]      click;
        logic [MAX_BUTTONS-1:0]      dbl;
        logic [MAX_BUTTONS-1:0]      lng;
    } scan_result_t;

    typedef struct packed {
        logic [PANEL_W-1:0]     panel;
        logic [NOW_W-1:0]       tick;
        bit                     fixed;
        logic [3:0][STEP_W-1:0] steps;
    } probe_row_t;

    // Rows marked fixed carry no button activity, so their slots and masks are all zero.
    probe_row_t probes [24] = '{
        '{16'hFC00, 16'd0, 1'b1, ALL_NONE},
        '{16'hFC01, 16'd1, 1'b1, ENC0_DOWN},
        '{16'hFC03, 16'd2, 1'b1, ALL_NONE},
        '{16'hFC02, 16'd3, 1'b1, ENC0_DOWN},
        '{16'hFCFF, 16'd4, 1'b1, ALL_UP},
        '{16'hFCAA, 16'd5, 1'b1, ALL_DOWN},
        '{16'hF801, 16'd10, 1'b0, ALL_NONE},
        '{16'hFC01, 16'd40, 1'b0, ALL_NONE},
        '{16'hF801, 16'd50, 1'b0, ALL_NONE},
        '{16'hFC01, 16'd55, 1'b0, ALL_NONE},
        '{16'hF801, 16'd60, 1'b0, ALL_NONE},
        '{16'hFC01, 16'd61, 1'b0, ALL_NONE},
        '{16'hF405, 16'd100, 1'b0, ALL_NONE},
        '{16'hF405, 16'd250, 1'b0, ALL_NONE},
        '{16'hFC05, 16'd251, 1'b0, ALL_NONE},
        '{16'hEC05, 16'd300, 1'b0, ALL_NONE},
        '{16'hFC05, 16'd301, 1'b0, ALL_NONE},
        '{16'hFC05, 16'd500, 1'b0, ALL_NONE},
        '{16'hDC05, 16'd65530, 1'b0, ALL_NONE},
        '{16'hFC05, 16'd65535, 1'b0, ALL_NONE},
        '{16'hDC05, 16'd5, 1'b0, ALL_NONE},
        '{16'h0000, 16'd0, 1'b0, ALL_NONE},
        '{16'hFFFF, 16'hFFFF, 1'b0, ALL_NONE},
        '{16'h0300, 16'h8000, 1'b0, ALL_NONE}
    };

    logic                       i_clk;
    logic                       i_rst_n = 1'b0;
    logic                       i_in_valid = 1'b0;
    logic                       o_in_stall;
    logic [PANEL_W-1:0]         i_panel_bits = '0;
    logic [NOW_W-1:0]           i_now_tick = '0;
    logic                       o_out_valid;
    logic                       i_out_stall = 1'b0;
    logic signed [STEP_W-1:0]   o_enc0_step, o_enc1_step, o_enc2_step, o_enc3_step;
    logic [SLOT_W-1:0]          o_enc0_slot, o_enc1_slot, o_enc2_slot, o_enc3_slot;
    logic [MAX_BUTTONS-1:0]     o_click_mask, o_double_click_mask, o_long_click_mask;
    logic                       i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]       i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]      i_cfg_data = '0;

    panel_encoder_button_scanner dut (.*);

    // Shadow of the configuration registers.
    logic [THRESH_W-1:0]    dbl_window = RST_DOUBLE_CLICK;
    logic [THRESH_W-1:0]    long_hold = RST_LONG_CLICK;
    logic [SHIFT_IDX_W-1:0] shift_sel = RST_SHIFT_INDEX;
    logic                   active_low_cfg = RST_ACTIVE_LOW;

    // Button and encoder history as the block should hold it.
    logic [7:0]             prev_enc = '0;
    logic [MAX_BUTTONS-1:0] prev_down = '0;
    logic [MAX_BUTTONS-1:0] armed = '0;
    logic [NOW_W-1:0]       press_tick [MAX_BUTTONS] = '{default: '0};

    scan_result_t expected_scans [$];
    int errors = 0;
    int snapshots_sent = 0;
    int tx_calm = 0;
    int rx_calm = 0;
    int stall_left = 0;
    int cycle_count = 0;
    bit offer_held = 1'b0;
    bit long_hold_done = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic scan_result_t predict_scan(input logic [PANEL_W-1:0] panel,
                                                  input logic [NOW_W-1:0] now);
        scan_result_t r;
        logic [MAX_BUTTONS-1:0] down;
        logic [NOW_W-1:0] age;
        logic shift_down, own;
        r = '0;
        for (int i = 0; i < MAX_BUTTONS; i++)
            down[i] = panel[BUTTON_BASE + i] ^ active_low_cfg;
        for (int i = 0; i < MAX_BUTTONS; i++) begin
            age = now - press_tick[i];
            if (down[i] && !prev_down[i]) begin
                if (armed[i]) begin
                    if (age < dbl_window) begin
                        r.dbl[i] = 1'b1;
                        armed[i] = 1'b0;
                    end
                end else begin
                    press_tick[i] = now;
                    armed[i] = 1'b1;
                end
            end
            age = now - press_tick[i];
            if (down[i] && armed[i] && age > long_hold) begin
                r.lng[i] = 1'b1;
                armed[i] = 1'b0;
            end
            if (!down[i] && armed[i]) begin
                if (age > long_hold) begin
                    armed[i] = 1'b0;
                end else if (age > dbl_window) begin
                    armed[i] = 1'b0;
                    r.click[i] = 1'b1;
                end
            end
        end
        prev_down = down;

        // A shift index past the last button never counts as held.
        shift_down = 1'b0;
        if (shift_sel < DEF_BUTTON_COUNT)
            shift_down = down[shift_sel];

        for (int e = 0; e < MAX_ENCODERS; e++) begin
            if (panel[2*e] != prev_enc[2*e]) begin
                r.step[e] = (panel[2*e] == panel[2*e+1]) ? STEP_UP : STEP_DOWN;
                own = (e < DEF_BUTTON_COUNT) && down[e];
                if (own)
                    r.slot[e] = shift_down ? SLOT_BTN_SHIFT : SLOT_BUTTON;
                else
                    r.slot[e] = shift_down ? SLOT_SHIFT : SLOT_NORMAL;
            end
        end
        prev_enc = panel[7:0];
        return r;
    endfunction

    // Idle length for either side: mostly none or short, a few long, with calm stretches.
    function automatic int idle_length(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic offer_snapshot(input logic [PANEL_W-1:0] panel, input logic [NOW_W-1:0] tick,
                                  input bit fixed, input logic [3:0][STEP_W-1:0] fixed_steps);
        scan_result_t want;
        int gap;
        i_in_valid <= 1'b1;
        i_panel_bits <= panel;
        i_now_tick <= tick;
        @(posedge i_clk);
        while (o_in_stall !== 1'b0) @(posedge i_clk);
        want = predict_scan(panel, tick);
        if (fixed) begin
            want = '0;
            want.step = fixed_steps;
            want.slot = {4{SLOT_NORMAL}};
        end
        expected_scans.push_back(want);
        snapshots_sent++;
        gap = idle_length(tx_calm);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            offer_held = 1'b0;
            repeat (gap) @(posedge i_clk);
        end else begin
            offer_held = 1'b1;
        end
    endtask

    task automatic settle_scans();
        if (offer_held) begin
            i_in_valid <= 1'b0;
            offer_held = 1'b0;
        end
        while (expected_scans.size() != 0) @(posedge i_clk);
    endtask

    // Writes every register, then one index past the list, which must be ignored.
    task automatic load_settings(input logic [CFG_DATA_W-1:0] dbl_v, lng_v, sh_v, al_v);
        logic [CFG_IDX_W-1:0] idx [5];
        logic [CFG_DATA_W-1:0] val [5];
        idx = '{REG_DOUBLE_CLICK, REG_LONG_CLICK, REG_SHIFT_INDEX, REG_ACTIVE_LOW,
                CFG_IDX_W'(REG_ACTIVE_LOW + 1 + $urandom_range(0, 3))};
        val = '{dbl_v, lng_v, sh_v, al_v, CFG_DATA_W'($urandom)};
        for (int k = 0; k < 5; k++) begin
            i_cfg_we <= 1'b1;
            i_cfg_index <= idx[k];
            i_cfg_data <= val[k];
            @(posedge i_clk);
            case (idx[k])
                REG_DOUBLE_CLICK: dbl_window = val[k];
                REG_LONG_CLICK:   long_hold = val[k];
                REG_SHIFT_INDEX:  shift_sel = val[k][SHIFT_IDX_W-1:0];
                REG_ACTIVE_LOW:   active_low_cfg = val[k][0];
                default: ;
            endcase
        end
        i_cfg_we <= 1'b0;
    endtask

    // Mostly press/release runs on one favored button with small tick steps,
    // quadrature steps on the encoders, and some noise and tick jumps.
    task automatic run_phase(input int beats);
        logic [MAX_BUTTONS-1:0] held, btn_bits;
        logic [7:0] enc;
        logic [NOW_W-1:0] tick;
        logic [1:0] bin;
        int hot, pick, r;
        held = '0;
        enc = 8'($urandom);
        tick = NOW_W'($urandom);
        hot = $urandom_range(0, MAX_BUTTONS - 1);
        repeat (beats) begin
            r = $urandom_range(0, 99);
            if (r < 60) tick += NOW_W'($urandom_range(0, 3));
            else if (r < 85) tick += NOW_W'($urandom_range(0, 15));
            else if (r < 97) tick += NOW_W'($urandom_range(16, 150));
            else tick = NOW_W'($urandom);

            if ($urandom_range(0, 99) < 8) hot = $urandom_range(0, MAX_BUTTONS - 1);
            r = $urandom_range(0, 99);
            pick = $urandom_range(0, MAX_BUTTONS - 1);
            if (r < 22) held[hot] = ~held[hot];
            else if (r < 30) held[pick] = ~held[pick];
            else if (r < 32) held = MAX_BUTTONS'($urandom);
            btn_bits = active_low_cfg ? ~held : held;
            if ($urandom_range(0, 99) < 4) btn_bits = MAX_BUTTONS'($urandom);

            if ($urandom_range(0, 99) < 5) begin
                enc = 8'($urandom);
            end else begin
                for (int e = 0; e < MAX_ENCODERS; e++) begin
                    r = $urandom_range(0, 99);
                    if (r < 30) begin
                        bin = {enc[2*e+1], enc[2*e+1] ^ enc[2*e]};
                        bin = (r < 15) ? bin + 2'd1 : bin - 2'd1;
                        enc[2*e +: 2] = bin ^ (bin >> 1);
                    end
                end
            end
            offer_snapshot({btn_bits, 2'($urandom), enc}, tick, 1'b0, ALL_NONE);
        end
    endtask

    task automatic compare_field(input string name, input logic [15:0] want, got);
        if (want !== got) begin
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: %s expected %0h actual %0h", $time, name, want, got);
        end
    endtask

    task automatic check_scan();
        scan_result_t got, want;
        got.step = {o_enc3_step, o_enc2_step, o_enc1_step, o_enc0_step};
        got.slot = {o_enc3_slot, o_enc2_slot, o_enc1_slot, o_enc0_slot};
        got.click = o_click_mask;
        got.dbl = o_double_click_mask;
        got.lng = o_long_click_mask;
        if (expected_scans.size() == 0) begin
            errors++;
            if (errors <= REPORT_CAP)
                $display("%0t: result beat with nothing expected, actual %0h", $time, got);
            return;
        end
        want = expected_scans.pop_front();
        for (int e = 0; e < MAX_ENCODERS; e++) begin
            compare_field($sformatf("enc%0d_step", e), want.step[e], got.step[e]);
            compare_field($sformatf("enc%0d_slot", e), want.slot[e], got.slot[e]);
        end
        compare_field("click_mask", want.click, got.click);
        compare_field("double_click_mask", want.dbl, got.dbl);
        compare_field("long_click_mask", want.lng, got.lng);
    endtask

    // Result side: check each accepted beat and decide the stall for the next edge.
    initial begin
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid === 1'b1 && !i_out_stall)
                check_scan();
            // One long hold-off while the sender keeps going, so the block backs up.
            if (!long_hold_done && snapshots_sent >= HOLD_AT_BEAT) begin
                stall_left = HOLD_CYCLES;
                long_hold_done = 1'b1;
            end
            if (stall_left > 0) begin
                i_out_stall <= 1'b1;
                stall_left--;
            end else begin
                i_out_stall <= 1'b0;
                stall_left = idle_length(rx_calm);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (probes[k])
            offer_snapshot(probes[k].panel, probes[k].tick, probes[k].fixed, probes[k].steps);
        settle_scans();

        run_phase(PHASE_BEATS);
        settle_scans();

        // Zero thresholds, shift index past the buttons, active-high buttons;
        // upper data bits are set to show they are dropped.
        load_settings(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFE);
        run_phase(PHASE_BEATS);
        settle_scans();

        load_settings(16'hFFFF, 16'hFFFF, 16'd5, 16'd1);
        run_phase(PHASE_BEATS);

        repeat (3) begin
            settle_scans();
            load_settings(CFG_DATA_W'($urandom_range(0, 60)), CFG_DATA_W'($urandom_range(0, 160)),
                          CFG_DATA_W'($urandom), CFG_DATA_W'($urandom));
            run_phase(PHASE_BEATS);
        end

        settle_scans();
        repeat (10) @(posedge i_clk);
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

@@ panel_encoder_button_scanner.f @@
src/pebs_pkg.sv
src/pebs_button.sv
src/pebs_encoder.sv
src/panel_encoder_button_scanner.sv
bench/panel_encoder_button_scanner_tb.sv
